// ----- sv/sdq_pkg.sv -----
// shared types and constants of the sorted deadline queue
package sdq_pkg;

  localparam int SDQ_CAPACITY = 16;
  localparam int SDQ_DL_W     = 32;
  localparam int SDQ_TAG_W    = 16;
  localparam int SDQ_CNT_W    = 5;
  localparam int SDQ_IN_W     = 48;
  localparam int SDQ_OUT_W    = 56;

  localparam logic SDQ_OP_INSERT = 1'b0;
  localparam logic SDQ_OP_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_REM_CMP,
    ST_REM_SH,
    ST_HEAD,
    ST_DONE
  } sdq_state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_ZERO,
    IDX_DEC,
    IDX_INC
  } sdq_idx_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_NEW_UP,
    WR_OLD_UP,
    WR_NEW_HERE,
    WR_OLD_DOWN
  } sdq_wr_sel_t;

  typedef struct packed {
    logic         load;
    sdq_idx_sel_t idx_sel;
    sdq_wr_sel_t  wr_sel;
    logic         set_ok;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         out_load;
  } sdq_cmd_t;

  typedef struct packed {
    logic op;
    logic full;
    logic empty;
    logic gt;
    logic hit;
    logic idx_zero;
    logic idx_last;
    logic out_free;
  } sdq_status_t;

endpackage

// ----- sv/sdq_ctrl.sv -----
// sequencer for the insert walk, the remove search and shift, and the result
module sdq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  sdq_pkg::sdq_status_t status,
  output sdq_pkg::sdq_cmd_t    cmd
);
  import sdq_pkg::*;

  sdq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd          = '0;
    cmd.idx_sel  = IDX_HOLD;
    cmd.wr_sel   = WR_NONE;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (status.op == SDQ_OP_INSERT) begin
          if (status.full) begin
            state_next = ST_HEAD;
          end else if (status.empty) begin
            cmd.idx_sel = IDX_ZERO;
            state_next  = ST_INS_PUT;
          end else begin
            cmd.idx_sel = IDX_TOP;
            state_next  = ST_INS_CMP;
          end
        end else begin
          if (status.empty) begin
            state_next = ST_HEAD;
          end else begin
            cmd.idx_sel = IDX_ZERO;
            state_next  = ST_REM_CMP;
          end
        end
      end
      // walk down from the tail, moving later deadlines up by one
      ST_INS_CMP: begin
        if (status.gt) begin
          cmd.wr_sel = WR_OLD_UP;
          if (status.idx_zero) begin
            state_next = ST_INS_PUT;
          end else begin
            cmd.idx_sel = IDX_DEC;
          end
        end else begin
          cmd.wr_sel  = WR_NEW_UP;
          cmd.set_ok  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = ST_HEAD;
        end
      end
      ST_INS_PUT: begin
        cmd.wr_sel  = WR_NEW_HERE;
        cmd.set_ok  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = ST_HEAD;
      end
      ST_REM_CMP: begin
        if (status.hit) begin
          cmd.set_ok = 1'b1;
          if (status.idx_last) begin
            cmd.cnt_dec = 1'b1;
            state_next  = ST_HEAD;
          end else begin
            cmd.idx_sel = IDX_INC;
            state_next  = ST_REM_SH;
          end
        end else if (status.idx_last) begin
          state_next = ST_HEAD;
        end else begin
          cmd.idx_sel = IDX_INC;
        end
      end
      // close the gap, one entry a step
      ST_REM_SH: begin
        cmd.wr_sel = WR_OLD_DOWN;
        if (status.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = ST_HEAD;
        end else begin
          cmd.idx_sel = IDX_INC;
        end
      end
      ST_HEAD: begin
        cmd.idx_sel = IDX_ZERO;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/sdq_datapath.sv -----
// entry memory, walk index, entry count and result register
module sdq_datapath #(
  parameter int CAPACITY = sdq_pkg::SDQ_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sdq_pkg::SDQ_IN_W-1:0]  s_tdata,
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sdq_pkg::SDQ_OUT_W-1:0] m_tdata,
  input  sdq_pkg::sdq_cmd_t             cmd,
  output sdq_pkg::sdq_status_t          status
);
  import sdq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                 op_r;
  logic [SDQ_DL_W-1:0]  dl_r;
  logic [SDQ_TAG_W-1:0] tg_r;
  logic                 ok_r;
  logic [AW-1:0]        idx, idx_next;
  logic [CW-1:0]        count;

  logic [SDQ_DL_W-1:0]  mem_dl [CAPACITY];
  logic [SDQ_TAG_W-1:0] mem_tg [CAPACITY];
  logic [SDQ_DL_W-1:0]  rd_dl;
  logic [SDQ_TAG_W-1:0] rd_tg;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SDQ_DL_W-1:0]  wr_dl;
  logic [SDQ_TAG_W-1:0] wr_tg;

  logic                 out_ok;
  logic [SDQ_CNT_W-1:0] out_count;
  logic                 out_hv;
  logic [SDQ_DL_W-1:0]  out_dl;
  logic [SDQ_TAG_W-1:0] out_tg;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= s_tuser;
      dl_r <= s_tdata[SDQ_DL_W-1:0];
      tg_r <= s_tdata[SDQ_DL_W +: SDQ_TAG_W];
    end
    if (cmd.load) begin
      ok_r <= 1'b0;
    end else if (cmd.set_ok) begin
      ok_r <= 1'b1;
    end
    idx <= idx_next;
  end

  always_comb begin
    unique case (cmd.idx_sel)
      IDX_HOLD: idx_next = idx;
      IDX_TOP:  idx_next = AW'(count - 1'b1);
      IDX_ZERO: idx_next = '0;
      IDX_DEC:  idx_next = idx - 1'b1;
      IDX_INC:  idx_next = idx + 1'b1;
      default:  idx_next = idx;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx;
    wr_dl   = dl_r;
    wr_tg   = tg_r;
    unique case (cmd.wr_sel)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_NEW_UP: begin
        wr_addr = idx + 1'b1;
      end
      WR_OLD_UP: begin
        wr_addr = idx + 1'b1;
        wr_dl   = rd_dl;
        wr_tg   = rd_tg;
      end
      WR_NEW_HERE: begin
        wr_addr = idx;
      end
      WR_OLD_DOWN: begin
        wr_addr = idx - 1'b1;
        wr_dl   = rd_dl;
        wr_tg   = rd_tg;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // read port follows the next index, so data lines up with the index register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_dl[wr_addr] <= wr_dl;
      mem_tg[wr_addr] <= wr_tg;
    end
    rd_dl <= mem_dl[idx_next];
    rd_tg <= mem_tg[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok    <= ok_r;
      out_count <= SDQ_CNT_W'(count);
      out_hv    <= (count != '0);
      out_dl    <= (count != '0) ? rd_dl : '0;
      out_tg    <= (count != '0) ? rd_tg : '0;
    end
  end

  assign m_tdata = {1'b0, out_tg, out_dl, out_hv, out_count, out_ok};

  assign status.op       = op_r;
  assign status.full     = (count == CW'(CAPACITY));
  assign status.empty    = (count == '0);
  assign status.gt       = (rd_dl > dl_r);
  assign status.hit      = (rd_tg == tg_r);
  assign status.idx_zero = (idx == '0);
  assign status.idx_last = ((CW'(idx) + CW'(1)) == count);
  assign status.out_free = !m_tvalid || m_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (count == $past(count) || count == $past(count) + 1'b1 ||
                     count == $past(count) - 1'b1))
    else $error("entry count moved by more than one");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) <= count))
    else $error("entry write beyond the held entries");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !status.full)
    else $error("insert into full table");

  // a match on the last entry sets the flag in the same cycle as the decrement
  a_dec_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> (!status.empty && (ok_r || cmd.set_ok)))
    else $error("remove counted without a match");

endmodule

// ----- sv/sorted_deadline_queue.sv -----
// sorted deadline queue: timer entries held in ascending deadline order
//
// input channel s_*: one transfer per operation; s_tuser is the op
// (0 insert, 1 remove by tag), s_tdata carries deadline and tag.
// output channel m_*: exactly one result transfer per operation with the
// success flag, the entry count after the operation and the front entry.
// operations are handled one at a time by a walk over the entry memory,
// which has one write and one registered read port:
//   insert: a walk down from the tail over the entries behind the new one
//   remove: a search from the front, then the later entries shifted down
//   insert into a full table or remove from an empty one: no walk
// the next transfer can be taken in the cycle after the result is loaded.
// a new operation may be accepted while the previous result still waits;
// it then holds before its result until the output register is free.
// when the receiver stalls the result stays stable in m_tdata.
// reset empties the table at once (the count is cleared, no clearing pass);
// entry memory contents are never used beyond the count.
module sorted_deadline_queue #(
  parameter int CAPACITY = sdq_pkg::SDQ_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // deadline [31:0], tag [47:32]
  input  logic [sdq_pkg::SDQ_IN_W-1:0]  s_tdata,
  // op [0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // ok [0], count [5:1], head_valid [6], head_deadline [38:7], head_tag [54:39]
  output logic [sdq_pkg::SDQ_OUT_W-1:0] m_tdata
);
  import sdq_pkg::*;

  sdq_cmd_t    cmd;
  sdq_status_t status;

  sdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sdq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ----- test/sorted_deadline_queue_checker.sv -----
// checker for the sorted deadline queue: predicts each result and compares it
`timescale 1ns / 1ps

module sorted_deadline_queue_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // deadline [31:0], tag [47:32]
  input  logic [sdq_pkg::SDQ_IN_W-1:0]  s_tdata,
  // op [0]
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // ok [0], count [5:1], head_valid [6], head_deadline [38:7], head_tag [54:39]
  input  logic [sdq_pkg::SDQ_OUT_W-1:0] m_tdata,
  output int                            fail_count,
  output int                            pending
);
  import sdq_pkg::*;

  typedef struct packed {
    logic                 ok;
    logic [SDQ_CNT_W-1:0] count;
    logic                 head_valid;
    logic [SDQ_DL_W-1:0]  head_deadline;
    logic [SDQ_TAG_W-1:0] head_tag;
  } timer_result_t;

  // shadow copy of the timer table, front entry at index 0
  logic [SDQ_DL_W-1:0]  shadow_deadline [SDQ_CAPACITY];
  logic [SDQ_TAG_W-1:0] shadow_tag      [SDQ_CAPACITY];
  int                   shadow_count;
  timer_result_t        awaited_results [$];

  task automatic apply_timer_op(input logic op, input logic [SDQ_DL_W-1:0] dl,
                                input logic [SDQ_TAG_W-1:0] tg,
                                output timer_result_t res);
    int pos;
    res = '0;
    pos = 0;
    if (op == SDQ_OP_INSERT) begin
      if (shadow_count < SDQ_CAPACITY) begin
        // equal deadlines keep arrival order
        while (pos < shadow_count && shadow_deadline[pos] <= dl) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_deadline[i] = shadow_deadline[i-1];
          shadow_tag[i]      = shadow_tag[i-1];
        end
        shadow_deadline[pos] = dl;
        shadow_tag[pos]      = tg;
        shadow_count++;
        res.ok = 1'b1;
      end
    end else begin
      while (pos < shadow_count && shadow_tag[pos] != tg) pos++;
      if (pos < shadow_count) begin
        for (int i = pos; i + 1 < shadow_count; i++) begin
          shadow_deadline[i] = shadow_deadline[i+1];
          shadow_tag[i]      = shadow_tag[i+1];
        end
        shadow_count--;
        res.ok = 1'b1;
      end
    end
    res.count = shadow_count[SDQ_CNT_W-1:0];
    if (shadow_count > 0) begin
      res.head_valid    = 1'b1;
      res.head_deadline = shadow_deadline[0];
      res.head_tag      = shadow_tag[0];
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    timer_result_t want, got;
    if (rst) begin
      shadow_count = 0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.ok            = m_tdata[0];
        got.count         = m_tdata[5:1];
        got.head_valid    = m_tdata[6];
        got.head_deadline = m_tdata[38:7];
        got.head_tag      = m_tdata[54:39];
        if (awaited_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("count", want.count, got.count);
          check_field("head_valid", want.head_valid, got.head_valid);
          check_field("head_deadline", want.head_deadline, got.head_deadline);
          check_field("head_tag", want.head_tag, got.head_tag);
        end
      end
      if (s_tvalid && s_tready) begin
        apply_timer_op(s_tuser, s_tdata[31:0], s_tdata[47:32], want);
        awaited_results.push_back(want);
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ----- test/sorted_deadline_queue_tb.sv -----
// testbench top for the sorted deadline queue: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module sorted_deadline_queue_tb;
  import sdq_pkg::*;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // deadline [31:0], tag [47:32]
  logic [SDQ_IN_W-1:0]  s_tdata  = '0;
  // op [0]
  logic                 s_tuser  = SDQ_OP_INSERT;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // ok [0], count [5:1], head_valid [6], head_deadline [38:7], head_tag [54:39]
  logic [SDQ_OUT_W-1:0] m_tdata;

  int send_idle  = 0;
  int recv_stall = 0;
  int fail_count;
  int pending;
  int idle_by_phase  [4] = '{0, 61, 0, 38};
  int stall_by_phase [4] = '{0, 0, 61, 38};

  // rough view of the tags held, only used to aim removes at live entries
  logic [SDQ_TAG_W-1:0] live_tags [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_stall);
  end

  sorted_deadline_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sorted_deadline_queue_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic send_op(input logic op, input logic [SDQ_DL_W-1:0] dl,
                         input logic [SDQ_TAG_W-1:0] tg);
    int idx;
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {tg, dl};
    do @(posedge clk); while (!s_tready);
    idx = -1;
    if (op == SDQ_OP_INSERT) begin
      if (live_tags.size() < SDQ_CAPACITY) live_tags.push_back(tg);
    end else begin
      for (int i = 0; i < live_tags.size(); i++)
        if (idx < 0 && live_tags[i] == tg) idx = i;
      if (idx >= 0) live_tags.delete(idx);
    end
  endtask

  task automatic random_op(input int insert_pct);
    logic                 op;
    logic [SDQ_DL_W-1:0]  dl;
    logic [SDQ_TAG_W-1:0] tg;
    int                   pick;
    op   = ($urandom_range(0, 99) < insert_pct) ? SDQ_OP_INSERT : SDQ_OP_REMOVE;
    dl   = $urandom();
    pick = $urandom_range(0, 9);
    if (op == SDQ_OP_INSERT) begin
      unique case (pick)
        0:       dl = '0;
        1:       dl = '1;
        2, 3, 4: dl = $urandom_range(0, 15);  // crowd of equal deadlines
        default: ;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 6)       tg = SDQ_TAG_W'($urandom_range(0, 31));
      else if (pick == 6) tg = $urandom_range(0, 1) ? '1 : '0;
      else                tg = SDQ_TAG_W'($urandom_range(0, 65535));
    end else if (pick < 7 && live_tags.size() > 0) begin
      tg = live_tags[$urandom_range(0, live_tags.size() - 1)];
    end else if (pick < 9) begin
      tg = SDQ_TAG_W'($urandom_range(0, 31));
    end else begin
      tg = SDQ_TAG_W'($urandom_range(0, 65535));
    end
    send_op(op, dl, tg);
  endtask

  initial begin
    int insert_pct;
    insert_pct = 50;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_op(SDQ_OP_REMOVE, 32'h0, 16'h0000);         // remove from an empty table
    send_op(SDQ_OP_INSERT, 32'hFFFF_FFFF, 16'h0000);
    send_op(SDQ_OP_INSERT, 32'h0, 16'hFFFF);          // new front entry
    send_op(SDQ_OP_INSERT, 32'h0, 16'h1234);          // equal deadline goes behind
    send_op(SDQ_OP_INSERT, 32'h5, 16'h1234);          // duplicate tag
    send_op(SDQ_OP_REMOVE, 32'hFFFF_FFFF, 16'h1234);  // frontmost duplicate only
    send_op(SDQ_OP_REMOVE, 32'h0, 16'hFFFF);
    send_op(SDQ_OP_REMOVE, 32'h0, 16'hABCD);          // tag not held
    for (int i = 0; i < 14; i++)
      send_op(SDQ_OP_INSERT, (i % 3 == 0) ? 32'h5 : 32'h1000_0000 * i, i[15:0]);
    send_op(SDQ_OP_INSERT, 32'h1, 16'h5555);          // table full, refused
    send_op(SDQ_OP_REMOVE, 32'h0, 16'h0000);
    send_op(SDQ_OP_REMOVE, 32'h0, 16'h1234);

    // random part, one idling pattern per phase
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = idle_by_phase[ph];
      recv_stall = stall_by_phase[ph];
      for (int n = 0; n < 357; n++) begin
        // drift between filling up and draining
        if (n % 50 == 0) insert_pct = $urandom_range(15, 85);
        random_op(insert_pct);
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[sorted_deadline_queue] OK");
    end else begin
      $display("[sorted_deadline_queue] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[sorted_deadline_queue] ERROR");
    $finish;
  end

endmodule
